// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types, constants and helpers shared by the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 64;
    localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_AW    = $clog2(MAP_WORDS);
    localparam int BIT_AW     = $clog2(WORD_BITS);
    localparam int BLK_AW     = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = 13;
    localparam int OFF_W      = 32;
    localparam int REGION_W   = 33;
    localparam int SHIFT_W    = 5;
    localparam int CFG_W      = 33;

    localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] BLOCKS_CAP = CNT_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_FORMAT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OOM     = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_USABLE   = 2'd0,
        CFG_SHIFT    = 2'd1,
        CFG_REGION   = 2'd2,
        CFG_RESERVED = 2'd3
    } t_cfg_idx;

    // result of the two priority searches
    typedef struct packed {
        logic               open_found;
        logic [WORD_AW-1:0] open_word;
        logic [BIT_AW-1:0]  clear_bit;
    } t_pick;

    function automatic logic [CNT_W-1:0] clamp_blocks(input logic [CNT_W-1:0] n);
        return (n > BLOCKS_CAP) ? BLOCKS_CAP : n;
    endfunction

    // content of a map word right after a format of n reserved blocks
    function automatic logic [WORD_BITS-1:0] fmt_word(input logic [CNT_W-1:0] n,
                                                      input logic [WORD_AW-1:0] w);
        logic [CNT_W-BIT_AW-1:0] nw;
        logic [CNT_W-BIT_AW-1:0] wx;
        nw = n[CNT_W-1:BIT_AW];
        wx = (CNT_W-BIT_AW)'(w);
        if (wx < nw)
            return {WORD_BITS{1'b1}};
        else if (wx == nw)
            return (WORD_BITS'(1) << n[BIT_AW-1:0]) - WORD_BITS'(1);
        else
            return '0;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/bba_pick.sv =====
// ----------------------------------------------------------------------------
// bba_pick
// Priority searches: first map word not full, lowest clear bit of a word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_pick (
    input  wire logic [bba_pkg::MAP_WORDS-1:0] i_full,
    input  wire logic [bba_pkg::WORD_BITS-1:0] i_word,
    output bba_pkg::t_pick                     o_pick
);
    import bba_pkg::*;

    always_comb begin
        o_pick.open_found = ~&i_full;
        o_pick.open_word  = '0;
        // lowest clear bit falls back to the top bit on a full word
        o_pick.clear_bit  = BIT_AW'(WORD_BITS - 1);
        for (int w = MAP_WORDS - 1; w >= 0; w--) begin
            if (!i_full[w]) begin
                o_pick.open_word = WORD_AW'(w);
            end
        end
        for (int b = WORD_BITS - 2; b >= 0; b--) begin
            if (!i_word[b]) begin
                o_pick.clear_bit = BIT_AW'(b);
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/bitmap_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit bitmap allocator: used bits in a 64x64 map RAM, full flags per word.
// ----------------------------------------------------------------------------
// sequence: alloc and a free that hits the map pass from accept through the
// address, read-modify-write and output states; format, ignored frees, unused
// commands and allocs with no open word skip read-modify-write. one item at a
// time: the next item is accepted once the last leaves the output state, later while a result waits.
// reset: synchronous, clears control state; the map reads as all zero through
// per-word valid bits, no clearing pass
`default_nettype none

module bitmap_block_allocator_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // slave side
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    input  wire logic [31:0]                 i_s_tdata,   // [31:0] free_offset
    input  wire logic [1:0]                  i_s_tuser,   // [1:0] cmd
    // master side
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic      [47:0]                 o_m_tdata,   // [1:0] status, [33:2]
                                                          // block_offset, [46:34]
                                                          // used_count, [47] zero
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [1:0]                  i_cfg_idx,
    input  wire logic [bba_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import bba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_MOD  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // configuration registers
    logic [CNT_W-1:0]    r_usable;
    logic [SHIFT_W-1:0]  r_shift;
    logic [REGION_W-1:0] r_region;
    logic [CNT_W-1:0]    r_reserved;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [OFF_W-1:0]     r_offset, n_offset;
    logic [WORD_AW-1:0]   r_addr, n_addr;
    logic [BIT_AW-1:0]    r_bit, n_bit;
    t_status              r_status, n_status;
    logic [OFF_W-1:0]     r_off, n_off;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [MAP_WORDS-1:0] r_vld, n_vld;
    logic [MAP_WORDS-1:0] r_full, n_full;
    logic [CNT_W-1:0]     r_fmt_n, n_fmt_n;
    logic                 r_rd_vld;
    logic                 r_m_valid, n_m_valid;
    t_status              r_m_status, n_m_status;
    logic [OFF_W-1:0]     r_m_off, n_m_off;
    logic [CNT_W-1:0]     r_m_cnt, n_m_cnt;

    logic                 ram_we;
    logic                 ram_re;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] bit_mask;
    logic [OFF_W-1:0]     free_idx;
    logic                 free_hit;
    logic [BLK_AW-1:0]    alloc_idx;
    logic [CNT_W-1:0]     alloc_limit;
    t_pick                pick;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // a word never written since the last format reads as the format pattern
    assign cur_word = r_rd_vld ? ram_q : fmt_word(r_fmt_n, r_addr);

    bba_pick u_pick (
        .i_full (r_full),
        .i_word (cur_word),
        .o_pick (pick)
    );

    assign free_idx    = r_offset >> r_shift;
    assign free_hit    = ({1'b0, r_offset} < r_region) &&
                         (free_idx[OFF_W-1:BLK_AW] == '0);
    assign alloc_idx   = {r_addr, pick.clear_bit};
    assign alloc_limit = clamp_blocks(r_usable);

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_offset   = r_offset;
        n_addr     = r_addr;
        n_bit      = r_bit;
        n_status   = r_status;
        n_off      = r_off;
        n_used     = r_used;
        n_vld      = r_vld;
        n_full     = r_full;
        n_fmt_n    = r_fmt_n;
        n_m_valid  = r_m_valid;
        n_m_status = r_m_status;
        n_m_off    = r_m_off;
        n_m_cnt    = r_m_cnt;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_wdata  = '0;
        rd_addr    = '0;
        new_word   = cur_word;
        bit_mask   = '0;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_cmd    = t_cmd'(i_s_tuser);
                    n_offset = i_s_tdata;
                    n_state  = S_ADDR;
                end
            end
            S_ADDR: begin
                n_off   = '0;
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_ALLOC: begin
                        n_status = ST_OOM;
                        if (pick.open_found) begin
                            rd_addr = pick.open_word;
                            ram_re  = 1'b1;
                            n_addr  = pick.open_word;
                            n_state = S_MOD;
                        end
                    end
                    CMD_FREE: begin
                        n_status = ST_IGNORED;
                        if (free_hit) begin
                            rd_addr  = free_idx[BLK_AW-1:BIT_AW];
                            ram_re   = 1'b1;
                            n_addr   = free_idx[BLK_AW-1:BIT_AW];
                            n_bit    = free_idx[BIT_AW-1:0];
                            n_status = ST_OK;
                            n_state  = S_MOD;
                        end
                    end
                    CMD_FORMAT: begin
                        n_status = ST_OK;
                        n_fmt_n  = clamp_blocks(r_reserved);
                        n_used   = clamp_blocks(r_reserved);
                        n_vld    = '0;
                        for (int w = 0; w < MAP_WORDS; w++) begin
                            n_full[w] = (CNT_W-BIT_AW)'(w) <
                                        n_fmt_n[CNT_W-1:BIT_AW];
                        end
                    end
                    default: begin
                        n_status = ST_IGNORED;
                    end
                endcase
            end
            S_MOD: begin
                n_state = S_DONE;
                if (r_cmd == CMD_ALLOC) begin
                    if (CNT_W'(alloc_idx) < alloc_limit) begin
                        bit_mask       = WORD_BITS'(1) << pick.clear_bit;
                        new_word       = cur_word | bit_mask;
                        ram_we         = 1'b1;
                        ram_wdata      = new_word;
                        n_vld[r_addr]  = 1'b1;
                        n_full[r_addr] = &new_word;
                        n_status       = ST_OK;
                        n_off          = OFF_W'(alloc_idx) << r_shift;
                        if (r_used != COUNT_MAX) begin
                            n_used = r_used + CNT_W'(1);
                        end
                    end
                end else begin
                    bit_mask = WORD_BITS'(1) << r_bit;
                    if (cur_word[r_bit]) begin
                        new_word       = cur_word & ~bit_mask;
                        ram_we         = 1'b1;
                        ram_wdata      = new_word;
                        n_vld[r_addr]  = 1'b1;
                        n_full[r_addr] = 1'b0;
                        if (r_used != '0) begin
                            n_used = r_used - CNT_W'(1);
                        end
                    end
                end
            end
            S_DONE: begin
                // output register loads when it is empty or being taken in the same cycle
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_off    = r_off;
                    n_m_cnt    = r_used;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_vld      <= '0;
            r_full     <= '0;
            r_fmt_n    <= '0;
            r_m_valid  <= 1'b0;
            r_usable   <= CNT_W'(4096);
            r_shift    <= SHIFT_W'(12);
            r_region   <= REGION_W'(33'd16777216);
            r_reserved <= CNT_W'(1);
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_vld     <= n_vld;
            r_full    <= n_full;
            r_fmt_n   <= n_fmt_n;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_USABLE:   r_usable   <= i_cfg_wdata[CNT_W-1:0];
                    CFG_SHIFT:    r_shift    <= i_cfg_wdata[SHIFT_W-1:0];
                    CFG_REGION:   r_region   <= i_cfg_wdata[REGION_W-1:0];
                    CFG_RESERVED: r_reserved <= i_cfg_wdata[CNT_W-1:0];
                    default:      r_usable   <= r_usable;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_offset   <= n_offset;
        r_addr     <= n_addr;
        r_bit      <= n_bit;
        r_status   <= n_status;
        r_off      <= n_off;
        r_m_status <= n_m_status;
        r_m_off    <= n_m_off;
        r_m_cnt    <= n_m_cnt;
        if (ram_re) begin
            r_rd_vld <= r_vld[rd_addr];
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_cnt, r_m_off, r_m_status};

endmodule

`default_nettype wire

// ===== sv/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_s_tvalid,
    input wire logic                      o_s_tready,
    input wire logic                      o_m_tvalid,
    input wire logic                      i_m_tready,
    input wire logic [47:0]               o_m_tdata
);
    import bba_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item in flight: accepting closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input open right after accept");

    // a command that fails or is ignored carries no offset
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] != ST_OK) |-> o_m_tdata[33:2] == '0)
        else $error("offset on a failed command");

    // status code and used count stay in range, and the pad bit stays zero
    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] != 2'd3) && (o_m_tdata[46:34] <= 13'd4096)
                       && !o_m_tdata[47])
        else $error("result field out of range");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("not idle after reset");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);

`default_nettype wire

// ===== sim/bba_alloc_checker.sv =====
// ----------------------------------------------------------------------------
// bba_alloc_checker
// Watches the command and response streams and the register port of the
// bitmap block allocator, keeps its own copy of the used map and settings,
// and compares every response with the one it works out for each command.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_alloc_checker (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // command stream
    input  wire logic                      i_s_tvalid,
    input  wire logic                      i_s_tready,
    input  wire logic [31:0]               i_s_tdata,   // [31:0] free_offset
    input  wire logic [1:0]                i_s_tuser,   // [1:0] cmd
    // response stream
    input  wire logic                      i_m_tvalid,
    input  wire logic                      i_m_tready,
    input  wire logic [47:0]               i_m_tdata,   // [1:0] status, [33:2]
                                                        // block_offset, [46:34]
                                                        // used_count, [47] zero
    // register port
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [bba_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bba_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [OFF_W-1:0]   offset;
        logic [CNT_W-1:0]   used;
    } t_reply;

    logic [WORD_BITS-1:0] map_bits [MAP_WORDS];
    logic [CNT_W-1:0]     used_blocks;
    logic [CNT_W-1:0]     cfg_usable;
    logic [SHIFT_W-1:0]   cfg_shift;
    logic [REGION_W-1:0]  cfg_region;
    logic [CNT_W-1:0]     cfg_reserved;
    t_reply               replies_due [$];

    // expected response of one command, updating the map copy on the way
    task automatic run_command(input t_cmd cmd, input logic [31:0] offs,
                               output t_reply rep);
        int         cap;
        int         nwords;
        int         w;
        int         b;
        int         blk;
        bit         searching;
        logic [31:0] fidx;
        rep.status = ST_IGNORED;
        rep.offset = '0;
        case (cmd)
            CMD_ALLOC: begin
                cap = (cfg_usable > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_usable);
                nwords = (cap + WORD_BITS - 1) / WORD_BITS;
                rep.status = ST_OOM;
                searching = 1'b1;
                for (w = 0; w < nwords && searching; w++) begin
                    if (map_bits[w] != '1) begin
                        searching = 1'b0;
                        b = 0;
                        while (b < WORD_BITS - 1 && map_bits[w][b])
                            b++;
                        blk = w * WORD_BITS + b;
                        // a free bit past the usable count is left clear
                        if (blk < cap) begin
                            map_bits[w][b] = 1'b1;
                            if (used_blocks != COUNT_MAX)
                                used_blocks++;
                            rep.status = ST_OK;
                            rep.offset = 32'(64'(blk) << cfg_shift);
                        end
                    end
                end
            end
            CMD_FREE: begin
                if (REGION_W'(offs) < cfg_region) begin
                    fidx = offs >> cfg_shift;
                    if (fidx < MAX_BLOCKS) begin
                        w = int'(fidx) / WORD_BITS;
                        b = int'(fidx) % WORD_BITS;
                        if (map_bits[w][b]) begin
                            map_bits[w][b] = 1'b0;
                            if (used_blocks != '0)
                                used_blocks--;
                        end
                        rep.status = ST_OK;
                    end
                end
            end
            CMD_FORMAT: begin
                cap = (cfg_reserved > MAX_BLOCKS) ? MAX_BLOCKS : int'(cfg_reserved);
                for (w = 0; w < MAP_WORDS; w++)
                    map_bits[w] = '0;
                for (blk = 0; blk < cap; blk++)
                    map_bits[blk / WORD_BITS][blk % WORD_BITS] = 1'b1;
                used_blocks = CNT_W'(cap);
                rep.status = ST_OK;
            end
            default: ;
        endcase
        rep.used = used_blocks;
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (!i_rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++)
                map_bits[w] = '0;
            used_blocks  = '0;
            cfg_usable   = CNT_W'(4096);
            cfg_shift    = SHIFT_W'(12);
            cfg_region   = REGION_W'(33'd16777216);
            cfg_reserved = CNT_W'(1);
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_USABLE:   cfg_usable   = i_cfg_wdata[CNT_W-1:0];
                    CFG_SHIFT:    cfg_shift    = i_cfg_wdata[SHIFT_W-1:0];
                    CFG_REGION:   cfg_region   = i_cfg_wdata[REGION_W-1:0];
                    CFG_RESERVED: cfg_reserved = i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tdata[1:0]);
                got.offset = i_m_tdata[33:2];
                got.used   = i_m_tdata[46:34];
                if (replies_due.size() == 0) begin
                    $error("response with no command waiting: %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        o_fail_count++;
                    end
                    if (got.offset !== want.offset) begin
                        $error("block_offset: expected %h, actual %h", want.offset,
                               got.offset);
                        o_fail_count++;
                    end
                    if (got.used !== want.used) begin
                        $error("used_count: expected %0d, actual %0d", want.used, got.used);
                        o_fail_count++;
                    end
                    if (i_m_tdata[47] !== 1'b0) begin
                        $error("pad bit: expected 0, actual %b", i_m_tdata[47]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                run_command(t_cmd'(i_s_tuser), i_s_tdata, want);
                replies_due.push_back(want);
            end
        end
        o_pending = replies_due.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb_bitmap_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_unit
// Drives alloc, free, format and unused commands into the allocator under
// several register settings and random stalls on both streams; the checker
// beside the block predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_block_allocator_unit;
    import bba_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASES      = 4;
    localparam int         PHASE_ITEMS = 140;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata = '0;
    logic [1:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [47:0]        m_tdata;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_idx = '0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;
    int                 snd_idle = 0;
    int                 rcv_idle = 0;
    logic [CNT_W-1:0]   cur_usable = CNT_W'(4096);
    logic [SHIFT_W-1:0] cur_shift = SHIFT_W'(12);
    logic [32:0]        cur_region = 33'd16777216;
    int                 snd_modes [3] = '{20, 45, 0};
    int                 rcv_modes [3] = '{45, 20, 0};

    always #5 clk = ~clk;

    bitmap_block_allocator_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    bba_alloc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("bitmap_block_allocator_unit regression: fail");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_command(input logic [1:0] cmd, input logic [31:0] offs);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= offs;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // only while idle; one register per cycle
    task automatic load_config(input logic [CNT_W-1:0] usable, input logic [SHIFT_W-1:0] shift,
                               input logic [32:0] region, input logic [CNT_W-1:0] reserved);
        logic [CFG_W-1:0] vals [4];
        vals[0] = CFG_W'(usable);
        vals[1] = CFG_W'(shift);
        vals[2] = CFG_W'(region);
        vals[3] = CFG_W'(reserved);
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= 2'(i);
            cfg_wdata <= vals[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        cur_usable = usable;
        cur_shift  = shift;
        cur_region = region;
        @(negedge clk);
    endtask

    // offset inside a block that may be in use, with random low bits
    function automatic logic [31:0] pick_held_offset();
        int          cap;
        logic [63:0] base;
        logic [31:0] low_mask;
        cap = (cur_usable > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_usable);
        if (cap == 0)
            cap = 1;
        base = 64'($urandom_range(0, cap - 1)) << cur_shift;
        low_mask = 32'((64'(1) << cur_shift) - 64'(1));
        return base[31:0] | ($urandom & low_mask);
    endfunction

    task automatic random_config;
        int               r;
        int               cap;
        logic [CNT_W-1:0] usable;
        logic [SHIFT_W-1:0] shift;
        logic [32:0]      region;
        logic [CNT_W-1:0] reserved;
        logic [63:0]      span;
        r = $urandom_range(0, 99);
        if (r < 50)      usable = CNT_W'($urandom_range(1, 200));
        else if (r < 70) usable = CNT_W'($urandom_range(1, 4096));
        else if (r < 85) usable = CNT_W'(4096);
        else if (r < 92) usable = CNT_W'(1);
        else if (r < 97) usable = CNT_W'($urandom_range(0, 8191));
        else             usable = '0;
        cap = (usable > MAX_BLOCKS) ? MAX_BLOCKS : int'(usable);
        if (cap == 0)
            cap = 1;
        r = $urandom_range(0, 99);
        if (r < 15)      shift = SHIFT_W'(3);
        else if (r < 30) shift = SHIFT_W'(20);
        else             shift = SHIFT_W'($urandom_range(3, 20));
        span = 64'(cap) << shift;
        r = $urandom_range(0, 99);
        if (r < 50)      region = span[32:0];
        else if (r < 70) region = 33'h1_0000_0000;
        else if (r < 85) region = {1'($urandom_range(0, 1)), $urandom};
        else             region = 33'($urandom_range(8, 65536));
        r = $urandom_range(0, 99);
        if (r < 40)      reserved = CNT_W'($urandom_range(0, cap / 2));
        else if (r < 60) reserved = '0;
        else if (r < 75) reserved = CNT_W'(1);
        else if (r < 85) reserved = CNT_W'(cap);
        else if (r < 95) reserved = CNT_W'($urandom_range(0, 4096));
        else             reserved = CNT_W'($urandom_range(4097, 8191));
        load_config(usable, shift, region, reserved);
    endtask

    task automatic random_item;
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)      send_command(CMD_ALLOC, $urandom);
        else if (r < 80) send_command(CMD_FREE, pick_held_offset());
        else if (r < 88) send_command(CMD_FREE, $urandom);
        else if (r < 92) send_command(CMD_FORMAT, $urandom);
        else if (r < 95) send_command(CMD_UNUSED, $urandom);
        else if (r < 98) send_command(CMD_FREE, 32'(cur_region - 33'd1));
        else             send_command(CMD_FREE, cur_region[31:0]);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        snd_idle = snd_modes[0];
        rcv_idle = rcv_modes[0];

        // reset settings: 4096 blocks of 4 KiB, 16 MiB region, one reserved
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_ALLOC, 32'hFFFF_FFFF);
        send_command(CMD_FREE, 32'h0000_1000);
        send_command(CMD_FREE, 32'h0000_1000);       // bit already clear
        send_command(CMD_FREE, 32'hFFFF_FFFF);       // outside the region
        send_command(CMD_FREE, 32'h00FF_FFFF);       // last block of the region
        send_command(CMD_UNUSED, 32'h0);
        send_command(CMD_FORMAT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        drain;

        // nothing usable: every alloc runs out
        load_config('0, SHIFT_W'(3), 33'd8, '0);
        send_command(CMD_FORMAT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'd7);
        send_command(CMD_FREE, 32'd8);
        drain;

        // oversized counts clamp to the map, whole map reserved
        load_config(CNT_W'(8191), SHIFT_W'(20), 33'h1_0000_0000, CNT_W'(8191));
        send_command(CMD_FORMAT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'hFFFF_FFFF);
        send_command(CMD_ALLOC, 32'h0);
        drain;

        // single block; free index past the map
        load_config(CNT_W'(1), SHIFT_W'(3), 33'h1_0000_0000, '0);
        send_command(CMD_FORMAT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'hFFFF_FFF8);
        drain;

        // wide shift: offsets wrap to 32 bits
        load_config(CNT_W'(70), SHIFT_W'(31), 33'h1_0000_0000, CNT_W'(65));
        send_command(CMD_FORMAT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'h8000_0000);
        drain;

        for (int mode = 0; mode < 3; mode++) begin
            snd_idle = snd_modes[mode];
            rcv_idle = rcv_modes[mode];
            for (int ph = 0; ph < PHASES; ph++) begin
                random_config();
                send_command(CMD_FORMAT, $urandom);
                for (int n = 0; n < PHASE_ITEMS; n++)
                    random_item();
                drain;
            end
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("bitmap_block_allocator_unit regression: pass");
        else
            $display("bitmap_block_allocator_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
